### sv/sme_pkg.sv
// Shared constants, types and arithmetic helpers for the simplex minimizer.
// Used by sme_div and simplex_minimizer_engine; depends on nothing else.
package sme_pkg;

	localparam int MAX_DIMS    = 8;
	localparam int VALUE_WIDTH = 32;
	localparam int VTX_W       = $clog2(MAX_DIMS + 1);
	localparam int COL_W       = $clog2(MAX_DIMS);
	localparam int NUM_ROWS    = MAX_DIMS + 2;
	localparam int ROW_W       = $clog2(NUM_ROWS);
	localparam int ADDR_W      = ROW_W + COL_W;
	localparam int SUM_W       = VALUE_WIDTH + $clog2(MAX_DIMS) + 1;
	localparam int EXT_W       = SUM_W + 2;
	localparam int STEP_W      = 17;
	localparam int MSTEP_W     = 16;
	localparam int TOL_W       = 24;
	localparam int NDIM_W      = 4;
	localparam int TOL_SHIFT   = TOL_W + 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int CMD_W       = 2;
	localparam int KIND_W      = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 56;

	localparam logic [CMD_W-1:0] CMD_LOAD_COORD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_VALUE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START      = 2'd2;
	localparam logic [CMD_W-1:0] CMD_OBJECTIVE  = 2'd3;

	localparam logic [KIND_W-1:0] KIND_EVAL  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BEST  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_VALUE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = 2'd2;

	typedef enum logic [1:0] {
		TK_REFLECT  = 2'd0,
		TK_EXPAND   = 2'd1,
		TK_CONTRACT = 2'd2
	} trial_kind_t;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	localparam logic signed [EXT_W-1:0] VMAX_E =
		{{(EXT_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
	localparam logic signed [EXT_W-1:0] VMIN_E =
		{{(EXT_W - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};

	function automatic value_t sat_value(input logic signed [EXT_W-1:0] x);
		value_t r;
		if (x > VMAX_E) begin
			r = VMAX_E[VALUE_WIDTH-1:0];
		end else if (x < VMIN_E) begin
			r = VMIN_E[VALUE_WIDTH-1:0];
		end else begin
			r = x[VALUE_WIDTH-1:0];
		end
		return r;
	endfunction

	// Halve with truncation toward zero.
	function automatic logic signed [EXT_W-1:0] half_tz(input logic signed [EXT_W-1:0] x);
		logic signed [EXT_W-1:0] t;
		t = x + {{(EXT_W - 1){1'b0}}, x[EXT_W-1]};
		return t >>> 1;
	endfunction

endpackage

### sv/sme_div.sv
// Bit-serial signed divider used for the centroid: one quotient bit per cycle.
// Depends on sme_pkg for the sum and dimension widths.
module sme_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [sme_pkg::SUM_W-1:0] dividend,
	input  logic [sme_pkg::NDIM_W-1:0]       divisor,
	output logic                             done,
	output logic signed [sme_pkg::SUM_W-1:0] quotient
);
	import sme_pkg::*;

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NDIM_W-1:0] rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [NDIM_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= dividend[SUM_W-1];
				quo_q  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
				rem_q  <= '0;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				rem_q <= fits ? NDIM_W'(trial - {1'b0, divisor}) : trial[NDIM_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

`ifndef SYNTH
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted mid-run");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && divisor != '0) |-> (rem_q < divisor)) else $error("remainder too big");
`endif

endmodule

### sv/simplex_minimizer_engine.sv
// Downhill simplex minimizer with the objective evaluated outside the block.
// Depends on sme_pkg and sme_div (centroid divider).
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid/s_tready     tuser cmd, tdata vertex/coord/value
//  m_*       out        m_tvalid/m_tready     tuser kind, tdata coord/value/steps, tlast
//  cfg_*     in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Loads are written on acceptance. A start or objective value runs a sequencer over the
// shared vertex memory port: a scan of the vertex values, the tolerance test, and the
// memory reads and the serial divider for each trial coordinate; a shrink rewrites every
// vertex but the lowest. Results leave through one output register; the sequencer waits
// on it when m_tready is low. s_tready is high only between runs.
// Reset clears the control state and the vertex row map; vertex storage is not cleared.
module simplex_minimizer_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sme_pkg::IN_TDATA_W-1:0]    s_tdata,  // vertex, coord_index, value
	input  logic [sme_pkg::CMD_W-1:0]         s_tuser,  // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sme_pkg::OUT_TDATA_W-1:0]   m_tdata,  // coord_index_res, result_value, steps
	output logic [sme_pkg::KIND_W-1:0]        m_tuser,  // kind
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sme_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sme_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sme_pkg::*;

	typedef enum logic [16:0] {
		S_WAIT  = 17'h00001,
		S_SCAN  = 17'h00002,
		S_CHK   = 17'h00004,
		S_CONV  = 17'h00008,
		S_RSCAN = 17'h00010,
		S_TADR  = 17'h00020,
		S_TACC  = 17'h00040,
		S_TDIV  = 17'h00080,
		S_TCMB  = 17'h00100,
		S_SADR1 = 17'h00200,
		S_SADR2 = 17'h00400,
		S_SWR   = 17'h00800,
		S_EADR  = 17'h01000,
		S_EOUT  = 17'h02000,
		S_EVAL  = 17'h04000,
		S_FIN1  = 17'h08000,
		S_FIN2  = 17'h10000
	} state_t;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_REFLECT  = 5'b00010,
		PH_EXPAND   = 5'b00100,
		PH_CONTRACT = 5'b01000,
		PH_SHRINK   = 5'b10000
	} phase_t;

	state_t      st_q;
	phase_t      ph_q;
	trial_kind_t tk_q;

	logic [NDIM_W-1:0]  num_dims_q;
	logic [TOL_W-1:0]   tol_q;
	logic [MSTEP_W-1:0] max_steps_q;
	logic [NDIM_W-1:0]  dims_n;

	// Vertex rows are renamed through a map; one spare row holds the trial point.
	logic [ROW_W-1:0] map_q [MAX_DIMS+1];
	logic [ROW_W-1:0] trial_row_q;
	logic [ROW_W-1:0] tmp_row_q;
	value_t           vals_q [MAX_DIMS+1];
	value_t           mem [2**ADDR_W];
	value_t           mem_rd_q;

	logic [VTX_W-1:0] h_q, l_q, i_q, j_q, sv_q, ev_q;
	logic [COL_W-1:0] col_q;
	logic [STEP_W-1:0] step_q;
	value_t            yh_q, yl_q, v_q, ph_val_q, plo_q;
	logic signed [SUM_W-1:0] sum_q, sum_nxt;
	logic [KIND_W-1:0] ekind_q;
	logic [VALUE_WIDTH+TOL_SHIFT:0] dsh_q;
	logic [TOL_W+VALUE_WIDTH:0]     prod_q;

	logic              out_valid_q, out_last_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [COL_W-1:0]  out_ci_q;
	value_t            out_val_q;
	logic [STEP_W-1:0] out_steps_q;

	logic              s_acc, slot_free, col_last;
	logic [VTX_W-1:0]  in_vx, midx, vidx, nsv, shr_next;
	logic [COL_W-1:0]  in_ci;
	value_t            in_v, vrd, trial_val, shrink_val;
	logic [ROW_W-1:0]  map_rd;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	value_t            mem_wd;
	logic              do_replace;
	logic              div_start, div_done;
	logic signed [SUM_W-1:0] cen;
	logic signed [EXT_W-1:0] cen_e, ph_e, r_e;
	logic [VALUE_WIDTH-1:0]  abs_h, abs_l;
	logic [VALUE_WIDTH:0]    diff, asum;

	assign in_vx = s_tdata[VTX_W-1:0];
	assign in_ci = s_tdata[VTX_W+COL_W-1:VTX_W];
	assign in_v  = $signed(s_tdata[VTX_W+COL_W+VALUE_WIDTH-1:VTX_W+COL_W]);

	assign s_tready  = (st_q == S_WAIT);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || m_tready;

	assign dims_n = (num_dims_q == '0) ? NDIM_W'(1) :
		(num_dims_q > NDIM_W'(MAX_DIMS)) ? NDIM_W'(MAX_DIMS) : num_dims_q;
	assign col_last = ({1'b0, col_q} == dims_n - 1'b1);

	always_comb begin
		unique case (st_q)
			S_WAIT:          midx = (ph_q == PH_IDLE) ? in_vx : h_q;
			S_TADR, S_TACC:  midx = j_q;
			S_SADR1, S_FIN1: midx = l_q;
			S_SADR2, S_SWR:  midx = i_q;
			S_EADR, S_EOUT:  midx = ev_q;
			S_FIN2:          midx = '0;
			default:         midx = h_q;
		endcase
	end
	assign map_rd = map_q[midx];
	assign vidx   = (st_q == S_FIN2) ? VTX_W'(0) : i_q;
	assign vrd    = vals_q[vidx];

	assign do_replace = s_acc && (ph_q != PH_IDLE) && (s_tuser == CMD_OBJECTIVE) &&
		(((ph_q == PH_REFLECT) && (in_v <= yl_q || in_v < yh_q)) ||
		 ((ph_q == PH_EXPAND) && in_v < yh_q) ||
		 ((ph_q == PH_CONTRACT) && in_v <= yh_q));

	// Centroid sum and trial arithmetic.
	assign sum_nxt = (j_q == h_q) ? sum_q : sum_q + SUM_W'(mem_rd_q);
	assign div_start = (st_q == S_TACC) && (j_q == dims_n);

	sme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nxt),
		.divisor  (dims_n),
		.done     (div_done),
		.quotient (cen)
	);

	assign cen_e = EXT_W'(cen);
	assign ph_e  = EXT_W'(ph_val_q);
	always_comb begin
		case (tk_q)
			TK_REFLECT: r_e = (cen_e <<< 1) - ph_e;
			TK_EXPAND:  r_e = (ph_e <<< 1) - cen_e;
			default:    r_e = half_tz(ph_e + cen_e);
		endcase
	end
	assign trial_val  = sat_value(r_e);
	assign shrink_val = sat_value(half_tz(EXT_W'(mem_rd_q) + EXT_W'(plo_q)));

	assign abs_h = yh_q[VALUE_WIDTH-1] ? VALUE_WIDTH'(-yh_q) : VALUE_WIDTH'(yh_q);
	assign abs_l = yl_q[VALUE_WIDTH-1] ? VALUE_WIDTH'(-yl_q) : VALUE_WIDTH'(yl_q);
	assign diff  = (VALUE_WIDTH + 1)'($signed({yh_q[VALUE_WIDTH-1], yh_q}) -
		$signed({yl_q[VALUE_WIDTH-1], yl_q}));
	assign asum  = {1'b0, abs_h} + {1'b0, abs_l};

	// Next shrink vertex to evaluate (nsv) and to rewrite (shr_next), skipping the lowest one.
	assign nsv = (sv_q + 1'b1 == l_q) ? sv_q + VTX_W'(2) : sv_q + 1'b1;
	assign shr_next = (i_q + 1'b1 == l_q) ? i_q + VTX_W'(2) : i_q + 1'b1;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = {map_rd, col_q};
		mem_wd = trial_val;
		unique case (st_q)
			S_WAIT: begin
				mem_we = s_acc && (ph_q == PH_IDLE) && (s_tuser == CMD_LOAD_COORD) &&
					(in_vx <= VTX_W'(MAX_DIMS));
				mem_wa = {map_rd, in_ci};
				mem_wd = in_v;
			end
			S_TCMB: begin
				mem_we = slot_free;
				mem_wa = {trial_row_q, col_q};
			end
			S_SWR: begin
				mem_we = 1'b1;
				mem_wd = shrink_val;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[{map_rd, col_q}];
	end

	always_ff @(posedge clk) begin
		if (s_acc && ph_q == PH_IDLE && s_tuser == CMD_LOAD_VALUE &&
			in_vx <= VTX_W'(MAX_DIMS)) begin
			vals_q[in_vx] <= in_v;
		end
		if (do_replace) begin
			vals_q[h_q] <= in_v;
		end
		if (s_acc && ph_q == PH_SHRINK && s_tuser == CMD_OBJECTIVE) begin
			vals_q[sv_q] <= in_v;
		end
		if (st_q == S_FIN2) begin
			vals_q[l_q] <= vrd;
			vals_q[0]   <= yl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q  <= NDIM_W'(2);
			tol_q       <= TOL_W'(1678);
			max_steps_q <= MSTEP_W'(5000);
		end else if (cfg_valid && ph_q == PH_IDLE) begin
			unique case (cfg_index)
				CFG_NUM_DIMS:  num_dims_q  <= cfg_data[NDIM_W-1:0];
				CFG_TOLERANCE: tol_q       <= cfg_data[TOL_W-1:0];
				CFG_MAX_STEPS: max_steps_q <= cfg_data[MSTEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_WAIT;
			ph_q        <= PH_IDLE;
			tk_q        <= TK_REFLECT;
			for (int k = 0; k <= MAX_DIMS; k++) begin
				map_q[k] <= ROW_W'(k);
			end
			trial_row_q <= ROW_W'(MAX_DIMS + 1);
			tmp_row_q   <= '0;
			h_q <= '0; l_q <= '0; i_q <= '0; j_q <= '0; sv_q <= '0; ev_q <= '0;
			col_q <= '0; step_q <= '0;
			yh_q <= '0; yl_q <= '0; v_q <= '0; ph_val_q <= '0; plo_q <= '0;
			sum_q <= '0; ekind_q <= KIND_EVAL; dsh_q <= '0; prod_q <= '0;
			out_valid_q <= 1'b0; out_last_q <= 1'b0; out_kind_q <= KIND_EVAL;
			out_ci_q <= '0; out_val_q <= '0; out_steps_q <= '0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (do_replace) begin
				map_q[h_q]  <= trial_row_q;
				trial_row_q <= map_rd;
				yh_q        <= in_v;
			end
			unique case (st_q)
				S_WAIT: begin
					if (s_acc && ph_q == PH_IDLE && s_tuser == CMD_START) begin
						step_q <= '0;
						i_q    <= '0;
						st_q   <= S_SCAN;
					end else if (s_acc && ph_q != PH_IDLE && s_tuser == CMD_OBJECTIVE) begin
						v_q <= in_v;
						unique case (ph_q)
							PH_REFLECT: begin
								if (in_v <= yl_q) begin
									tk_q <= TK_EXPAND; ph_q <= PH_EXPAND;
									col_q <= '0; j_q <= '0; sum_q <= '0; st_q <= S_TADR;
								end else if (in_v < yh_q) begin
									i_q <= '0; st_q <= S_RSCAN;
								end else begin
									tk_q <= TK_CONTRACT; ph_q <= PH_CONTRACT;
									col_q <= '0; j_q <= '0; sum_q <= '0; st_q <= S_TADR;
								end
							end
							PH_EXPAND: begin
								i_q <= '0; st_q <= S_SCAN;
							end
							PH_CONTRACT: begin
								if (in_v <= yh_q) begin
									i_q <= '0; st_q <= S_SCAN;
								end else begin
									ph_q  <= PH_SHRINK;
									i_q   <= (l_q == '0) ? VTX_W'(1) : VTX_W'(0);
									col_q <= '0;
									st_q  <= S_SADR1;
								end
							end
							PH_SHRINK: begin
								if (nsv > dims_n) begin
									i_q <= '0; st_q <= S_SCAN;
								end else begin
									sv_q <= nsv; ev_q <= nsv; ekind_q <= KIND_EVAL;
									col_q <= '0; st_q <= S_EADR;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (i_q == '0) begin
						h_q <= '0; l_q <= '0; yh_q <= vrd; yl_q <= vrd;
					end else begin
						if (vrd < yl_q) begin
							l_q <= i_q; yl_q <= vrd;
						end
						if (vrd > yh_q) begin
							h_q <= i_q; yh_q <= vrd;
						end
					end
					if (i_q == dims_n) begin
						step_q <= step_q + 1'b1;
						st_q   <= S_CHK;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_CHK: begin
					if (step_q > STEP_W'(max_steps_q)) begin
						st_q <= S_FIN1;
					end else begin
						dsh_q  <= {diff, {TOL_SHIFT{1'b0}}};
						prod_q <= tol_q * asum;
						st_q   <= S_CONV;
					end
				end
				S_CONV: begin
					// Converged when yh is zero or 2|yh-yl| < tol * (|yh|+|yl|), tol read as a fraction of 2^24, in exact integers.
					if (yh_q == '0 || dsh_q < {1'b0, prod_q}) begin
						st_q <= S_FIN1;
					end else begin
						tk_q <= TK_REFLECT; ph_q <= PH_REFLECT;
						col_q <= '0; j_q <= '0; sum_q <= '0; st_q <= S_TADR;
					end
				end
				S_RSCAN: begin
					if (i_q != h_q && v_q <= vrd) begin
						i_q <= '0; st_q <= S_SCAN;
					end else if (i_q == dims_n) begin
						tk_q <= TK_CONTRACT; ph_q <= PH_CONTRACT;
						col_q <= '0; j_q <= '0; sum_q <= '0; st_q <= S_TADR;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_TADR: st_q <= S_TACC;
				S_TACC: begin
					if (j_q == h_q) begin
						ph_val_q <= mem_rd_q;
					end
					sum_q <= sum_nxt;
					if (j_q == dims_n) begin
						st_q <= S_TDIV;
					end else begin
						j_q  <= j_q + 1'b1;
						st_q <= S_TADR;
					end
				end
				S_TDIV: begin
					if (div_done) begin
						st_q <= S_TCMB;
					end
				end
				S_TCMB: begin
					if (slot_free) begin
						out_valid_q <= 1'b1; out_kind_q <= KIND_EVAL; out_ci_q <= col_q;
						out_val_q <= trial_val; out_steps_q <= '0; out_last_q <= col_last;
						if (col_last) begin
							st_q <= S_WAIT;
						end else begin
							col_q <= col_q + 1'b1; j_q <= '0; sum_q <= '0; st_q <= S_TADR;
						end
					end
				end
				S_SADR1: st_q <= S_SADR2;
				S_SADR2: begin
					plo_q <= mem_rd_q;
					st_q  <= S_SWR;
				end
				S_SWR: begin
					if (col_last) begin
						col_q <= '0;
						if (shr_next > dims_n) begin
							sv_q <= (l_q == '0) ? VTX_W'(1) : VTX_W'(0);
							ev_q <= (l_q == '0) ? VTX_W'(1) : VTX_W'(0);
							ekind_q <= KIND_EVAL;
							st_q <= S_EADR;
						end else begin
							i_q  <= shr_next;
							st_q <= S_SADR1;
						end
					end else begin
						col_q <= col_q + 1'b1;
						st_q  <= S_SADR1;
					end
				end
				S_EADR: st_q <= S_EOUT;
				S_EOUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1; out_kind_q <= ekind_q; out_ci_q <= col_q;
						out_val_q <= mem_rd_q; out_steps_q <= '0;
						out_last_q <= col_last && (ekind_q == KIND_EVAL);
						if (col_last) begin
							st_q <= (ekind_q == KIND_EVAL) ? S_WAIT : S_EVAL;
						end else begin
							col_q <= col_q + 1'b1;
							st_q  <= S_EADR;
						end
					end
				end
				S_EVAL: begin
					if (slot_free) begin
						out_valid_q <= 1'b1; out_kind_q <= KIND_VALUE; out_ci_q <= '0;
						out_val_q <= yl_q; out_steps_q <= step_q; out_last_q <= 1'b1;
						ph_q <= PH_IDLE;
						st_q <= S_WAIT;
					end
				end
				S_FIN1: begin
					tmp_row_q <= map_rd;
					st_q      <= S_FIN2;
				end
				S_FIN2: begin
					// The lowest vertex trades places with vertex zero.
					map_q[l_q] <= map_rd;
					map_q[0]   <= tmp_row_q;
					ev_q <= '0; ekind_q <= KIND_BEST; col_q <= '0;
					st_q <= S_EADR;
				end
				default: st_q <= S_WAIT;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_TDATA_W - COL_W - VALUE_WIDTH - STEP_W){1'b0}},
		out_steps_q, out_val_q, out_ci_q};

`ifndef SYNTH
	a_trial_row_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_TACC) |-> (trial_row_q != map_q[h_q]))
		else $error("trial row aliases the highest vertex");
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == S_TDIV)) else $error("divider finished outside its wait");
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(st_q) == S_TCMB || $past(st_q) == S_EOUT ||
		$past(st_q) == S_EVAL)) else $error("result loaded from wrong state");
	a_hl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_CHK) |-> (h_q <= dims_n && l_q <= dims_n))
		else $error("extreme vertex out of range");
	a_busy_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_TCMB || st_q == S_SWR) |-> (ph_q != PH_IDLE))
		else $error("sequencer working while idle");
`endif

endmodule
